// ===== rtl/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared constants, types and the digit-to-character mapping used by the
// integer to ASCII radix converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    // Default geometry
    localparam int DEFAULT_VALUE_BITS = 32;
    localparam int DEFAULT_MAX_DIGITS = 32;

    // Field widths
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 8;

    // Radix register
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

    // Quotient bits retired by the divider per cycle
    localparam int STEP_BITS = 8;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Character codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_A     = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] LAST_DEC    = 8'd9;
    localparam logic [CHAR_W-1:0] DEC_SPAN    = 8'd10;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SIGN,
        BK_READ,
        BK_EMIT
    } back_state_t;

    // Map one digit to its character: 0..9 then A..Z
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d_ext > LAST_DEC)
            return d_ext - DEC_SPAN + ASCII_A;
        return d_ext + ASCII_ZERO;
    endfunction

endpackage

// ===== rtl/itoa_front.sv =====
// ----------------------------------------------------------------------------
// itoa_front
// Holds the radix register, accepts input beats and classifies each value:
// effective radix, sign and magnitude, packed for the work queue.
// ----------------------------------------------------------------------------
module itoa_front #(
    parameter int VALUE_BITS = itoa_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [itoa_pkg::RADIX_W-1:0]            cfg_wr_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [VALUE_BITS-1:0]            value,
    input  logic                                    q_full,
    output logic                                    q_push,
    output logic [VALUE_BITS+itoa_pkg::RADIX_W:0]   q_wdata
);
    import itoa_pkg::*;

    logic [RADIX_W-1:0]    radix_reg;
    logic [RADIX_W-1:0]    radix_next;
    logic [RADIX_W-1:0]    base_eff;
    logic [VALUE_BITS-1:0] value_u;
    logic [VALUE_BITS-1:0] mag;
    logic                  neg;

    // Radix register; the user must write it only while the block is idle, the block itself does not enforce this
    always_comb
    begin
        radix_next = radix_reg;
        if (cfg_wr_en)
            radix_next = cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_RESET;
        else
            radix_reg <= radix_next;
    end

    // Saturate the radix into the legal range
    always_comb
    begin
        if (radix_reg inside {[RADIX_MIN:RADIX_MAX]})
            base_eff = radix_reg;
        else if (radix_reg < RADIX_MIN)
            base_eff = RADIX_MIN;
        else
            base_eff = RADIX_MAX;
    end

    // Split sign and magnitude; only decimal is signed
    always_comb
    begin
        value_u = value;
        neg     = (base_eff == RADIX_DEC) && value_u[VALUE_BITS-1];
        mag     = neg ? (~value_u + 1'b1) : value_u;
    end

    // Push accepted beats straight into the queue
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign q_wdata  = {neg, base_eff, mag};

endmodule

// ===== rtl/itoa_queue.sv =====
// ----------------------------------------------------------------------------
// itoa_queue
// Short first-in first-out queue that decouples the classifier from the
// conversion sequencer.
// ----------------------------------------------------------------------------
module itoa_queue #(
    parameter int WIDTH = itoa_pkg::DEFAULT_VALUE_BITS + itoa_pkg::RADIX_W + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] rdata
);
    import itoa_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== rtl/itoa_back.sv =====
// ----------------------------------------------------------------------------
// itoa_back
// Conversion sequencer: divides the magnitude by the radix with a long
// divider that retires several quotient bits per cycle, stores the digits
// least significant first, then sends the sign and digits out in reverse.
// ----------------------------------------------------------------------------
module itoa_back #(
    parameter int VALUE_BITS = itoa_pkg::DEFAULT_VALUE_BITS,
    parameter int MAX_DIGITS = itoa_pkg::DEFAULT_MAX_DIGITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    q_valid,
    input  logic [VALUE_BITS+itoa_pkg::RADIX_W:0]   q_data,
    output logic                                    q_pop,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [itoa_pkg::CHAR_W-1:0]             char_code,
    output logic                                    last_char
);
    import itoa_pkg::*;

    localparam int DIV_STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS  = DIV_STEPS * STEP_BITS;
    localparam int STEP_CW   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W    = $clog2(MAX_DIGITS);

    back_state_t state_reg;
    back_state_t state_next;

    logic [PAD_BITS-1:0] quot_reg;
    logic [PAD_BITS-1:0] quot_next;
    logic [RADIX_W-1:0]  rem_reg;
    logic [RADIX_W-1:0]  rem_next;
    logic [RADIX_W-1:0]  base_reg;
    logic [RADIX_W-1:0]  base_next;
    logic                neg_reg;
    logic                neg_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [STEP_CW-1:0]  step_reg;
    logic [STEP_CW-1:0]  step_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CHAR_W-1:0]   char_reg;
    logic [CHAR_W-1:0]   char_next;
    logic                last_reg;
    logic                last_next;

    logic [RADIX_W-1:0]  digit_mem [MAX_DIGITS];
    logic [RADIX_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic                mem_we;

    logic [PAD_BITS-1:0] q_work;
    logic [RADIX_W:0]    t_work;
    logic [RADIX_W-1:0]  r_work;
    logic [PAD_BITS-1:0] div_quot;
    logic [RADIX_W-1:0]  div_rem;
    logic [CNT_W-1:0]    count_inc;
    logic [CNT_W-1:0]    limit;
    logic                div_last;
    logic                div_done;
    logic                out_free;

    logic                in_neg;
    logic [RADIX_W-1:0]  in_base;
    logic [VALUE_BITS-1:0] in_mag;

    assign {in_neg, in_base, in_mag} = q_data;

    assign out_free  = !out_valid_reg || !out_stall;
    assign count_inc = count_reg + 1'b1;
    assign limit     = neg_reg ? CNT_W'(MAX_DIGITS - 1) : CNT_W'(MAX_DIGITS);
    assign div_last  = (step_reg == STEP_CW'(DIV_STEPS - 1));
    assign div_done  = (div_quot == '0) || (count_inc >= limit);
    assign wr_addr   = count_reg[ADDR_W-1:0];
    assign rd_addr   = ADDR_W'(count_reg - 1'b1);

    // Long division: retire STEP_BITS quotient bits per cycle
    always_comb
    begin
        q_work = quot_reg;
        r_work = rem_reg;
        t_work = '0;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            t_work = {r_work, q_work[PAD_BITS-1]};
            q_work = {q_work[PAD_BITS-2:0], 1'b0};
            if (t_work >= {1'b0, base_reg})
            begin
                t_work    = t_work - {1'b0, base_reg};
                q_work[0] = 1'b1;
            end
            r_work = t_work[RADIX_W-1:0];
        end
        div_quot = q_work;
        div_rem  = r_work;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (q_valid)
                    state_next = BK_DIV;
            BK_DIV:
                if (div_last && div_done)
                    state_next = neg_reg ? BK_SIGN : BK_READ;
            BK_SIGN:
                if (out_free)
                    state_next = BK_READ;
            BK_READ:
                state_next = BK_EMIT;
            BK_EMIT:
                if (out_free)
                    state_next = (count_reg == CNT_W'(1)) ? BK_IDLE : BK_READ;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        q_pop          = 1'b0;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        base_next      = base_reg;
        neg_next       = neg_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        mem_we         = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        case (state_reg)
            BK_IDLE:
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    quot_next  = PAD_BITS'(in_mag);
                    rem_next   = '0;
                    base_next  = in_base;
                    neg_next   = in_neg;
                    count_next = '0;
                    step_next  = '0;
                end
            BK_DIV:
            begin
                quot_next = div_quot;
                rem_next  = div_rem;
                step_next = step_reg + 1'b1;
                if (div_last)
                begin
                    mem_we     = 1'b1;
                    count_next = count_inc;
                    rem_next   = '0;
                    step_next  = '0;
                end
            end
            BK_SIGN:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = ASCII_MINUS;
                    last_next      = 1'b0;
                end
            BK_READ:
                ;
            BK_EMIT:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = digit_char(rd_data_reg);
                    last_next      = (count_reg == CNT_W'(1));
                    count_next     = count_reg - 1'b1;
                end
            default:
                ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    // Digit store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_mem[wr_addr] <= div_rem;
        if (state_reg == BK_READ)
            rd_data_reg <= digit_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

    // Digit count never runs past the store
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count exceeds store depth");

    // Divider only runs with a legal radix
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_DIV |-> (base_reg >= RADIX_MIN && base_reg <= RADIX_MAX))
        else $error("divider running with illegal radix");

    // Read-out never starts on an empty digit list
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READ || state_reg == BK_EMIT) |-> count_reg != '0)
        else $error("read-out with no digits left");

    // Final character ends the item
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EMIT && out_free && count_reg == CNT_W'(1))
        |=> (state_reg == BK_IDLE && out_valid_reg && last_reg))
        else $error("final character not flagged or sequencer not idle");

endmodule

// ===== rtl/integer_to_ascii_radix_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_core
// Integer to ASCII text converter with a programmable radix of 2 to 36.
// ----------------------------------------------------------------------------
// Usage:
//   Write the radix on cfg_wr_en/cfg_wr_data while idle; it resets to 10 and
//   saturates into 2..36. Each input beat (in_valid, in_stall, value) carries
//   one integer. The output channel (out_valid, out_stall) sends one beat per
//   character, most significant first, with last_char set on the final one.
//   In radix 10 a negative value is led by '-'; other radices read the value
//   as unsigned.
// Timing:
//   The front classifies a beat and queues it in the same cycle; the queue
//   holds two items. The back divides with one shared long divider that
//   retires 8 quotient bits per cycle in state BK_DIV and stores each digit;
//   it then sends a minus sign from BK_SIGN if needed, reads each digit
//   from the digit store in BK_READ and sends it in BK_EMIT. The back takes
//   the next item from the queue only after the last character of an item.
// Reset and stall:
//   Reset empties the queue and output register and sets the radix to 10.
//   A stalled receiver holds the output beat; the back waits, and the queue
//   keeps accepting input until it is full.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_core #(
    parameter int VALUE_BITS = itoa_pkg::DEFAULT_VALUE_BITS,
    parameter int MAX_DIGITS = itoa_pkg::DEFAULT_MAX_DIGITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [itoa_pkg::RADIX_W-1:0]  cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_BITS-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [itoa_pkg::CHAR_W-1:0]   char_code,
    output logic                          last_char
);
    import itoa_pkg::*;

    localparam int ENTRY_W = VALUE_BITS + RADIX_W + 1;

    logic               q_push;
    logic               q_full;
    logic [ENTRY_W-1:0] q_wdata;
    logic               q_pop;
    logic               q_not_empty;
    logic [ENTRY_W-1:0] q_rdata;

    // Accept and classify
    itoa_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    // Decouple front and back
    itoa_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    // Convert and send characters
    itoa_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last_char (last_char)
    );

endmodule
